[sv/vn_pkg.sv]
// Package: widths and types for the vector normalizer.
package vn_pkg;
    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 14;
    localparam int OUT_W       = FRAC_BITS + 2;
    localparam int SQ_W        = 2 * COORD_WIDTH;
    localparam int SUM_W       = 2 * COORD_WIDTH + 2;
    localparam int ERR_W       = 2 * COORD_WIDTH + 2 * FRAC_BITS + 6;
    localparam int N_ITER      = FRAC_BITS + 1;
    typedef logic signed [ERR_W-1:0] t_err;
    typedef logic [FRAC_BITS:0]      t_quot;
endpackage

[sv/vector3_normalizer.sv]
// Top level: pipelined 3-component vector normalizer.
// Register stages: input, square, sum, divider init, one per quotient bit, output; three lanes.
// Throughput: one transaction per cycle while the output does not stall.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits; data registers are not reset.
module vector3_normalizer import vn_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_comp_x,
    input  logic signed [COORD_WIDTH-1:0] i_comp_y,
    input  logic signed [COORD_WIDTH-1:0] i_comp_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [OUT_W-1:0]       o_unit_x,
    output logic signed [OUT_W-1:0]       o_unit_y,
    output logic signed [OUT_W-1:0]       o_unit_z,
    output logic                          o_zero_vector
);
    logic en;
    logic [COORD_WIDTH-1:0] n_mag [3];
    logic                   n_neg [3];
    logic [COORD_WIDTH-1:0] r0_mag [3];
    logic                   r0_neg [3];
    logic                   r_v0, r_v1, r_v2;
    logic [SQ_W-1:0]        r1_sq [3];
    logic                   r1_neg [3];
    logic [SQ_W-1:0]        r2_sq [3];
    logic                   r2_neg [3];
    logic [SUM_W-1:0]       r2_s;
    t_err                   r_e [N_ITER+1][3];
    t_err                   r_p [N_ITER+1][3];
    t_quot                  r_q [N_ITER+1][3];
    logic                   r_neg [N_ITER+1][3];
    t_err                   r_s [N_ITER+1];
    logic                   r_z [N_ITER+1];
    logic [N_ITER:0]        r_v;
    logic                   r_ov, r_oz;
    logic signed [OUT_W-1:0] r_ou [3];

    assign en      = !(r_ov && i_stall);
    assign o_stall = !en;

    always_comb begin
        logic [COORD_WIDTH-1:0] raw [3];
        raw[0] = i_comp_x;
        raw[1] = i_comp_y;
        raw[2] = i_comp_z;
        for (int l = 0; l < 3; l++) begin
            n_neg[l] = raw[l][COORD_WIDTH-1];
            n_mag[l] = n_neg[l] ? (~raw[l] + 1'b1) : raw[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v  <= {r_v[N_ITER-1:0], r_v2};
            r_ov <= r_v[N_ITER];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                r0_mag[l] <= n_mag[l];
                r0_neg[l] <= n_neg[l];
                r1_sq[l]  <= SQ_W'(r0_mag[l]) * SQ_W'(r0_mag[l]);
                r1_neg[l] <= r0_neg[l];
                r2_sq[l]  <= r1_sq[l];
                r2_neg[l] <= r1_neg[l];
            end
            r2_s <= SUM_W'(r1_sq[0]) + SUM_W'(r1_sq[1]) + SUM_W'(r1_sq[2]);
            // init: E = a^2 * 2^(2F+2) - s, P = -s
            r_s[0] <= ERR_W'(r2_s);
            r_z[0] <= (r2_s == '0);
            for (int l = 0; l < 3; l++) begin
                r_e[0][l]   <= (ERR_W'(r2_sq[l]) <<< (2 * FRAC_BITS + 2)) - ERR_W'(r2_s);
                r_p[0][l]   <= -ERR_W'(r2_s);
                r_q[0][l]   <= '0;
                r_neg[0][l] <= r2_neg[l];
            end
            for (int k = 1; k <= N_ITER; k++) begin
                r_s[k] <= r_s[k-1];
                r_z[k] <= r_z[k-1];
                for (int l = 0; l < 3; l++) begin
                    t_err dl;
                    int   b;
                    b  = N_ITER - k;
                    dl = (r_p[k-1][l] <<< (b + 2)) + (r_s[k-1] <<< (2 * b + 2));
                    r_neg[k][l] <= r_neg[k-1][l];
                    if (!r_q[k-1][l][FRAC_BITS] && (dl <= r_e[k-1][l])) begin
                        r_e[k][l] <= r_e[k-1][l] - dl;
                        r_p[k][l] <= r_p[k-1][l] + (r_s[k-1] <<< (b + 1));
                        r_q[k][l] <= r_q[k-1][l] | (t_quot'(1) << b);
                    end else begin
                        r_e[k][l] <= r_e[k-1][l];
                        r_p[k][l] <= r_p[k-1][l];
                        r_q[k][l] <= r_q[k-1][l];
                    end
                end
            end
            r_oz <= r_z[N_ITER];
            for (int l = 0; l < 3; l++) begin
                if (r_z[N_ITER]) begin
                    r_ou[l] <= '0;
                end else if (r_neg[N_ITER][l]) begin
                    r_ou[l] <= -$signed(OUT_W'(r_q[N_ITER][l]));
                end else begin
                    r_ou[l] <= $signed(OUT_W'(r_q[N_ITER][l]));
                end
            end
        end
    end

    assign o_valid       = r_ov;
    assign o_unit_x      = r_ou[0];
    assign o_unit_y      = r_ou[1];
    assign o_unit_z      = r_ou[2];
    assign o_zero_vector = r_oz;

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid) else $error("stall without pending result");
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_vector) |-> (o_unit_x == 0 && o_unit_y == 0 && o_unit_z == 0))
        else $error("zero vector with nonzero output");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_unit_x <= (1 <<< FRAC_BITS) && o_unit_x >= -(1 <<< FRAC_BITS)))
        else $error("unit_x out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_stall) |-> (o_valid && $stable(o_unit_x) && $stable(o_zero_vector)))
        else $error("stalled result changed");
endmodule

[test/vector3_normalizer_tb.sv]
// Testbench for vector3_normalizer: directed table plus random vectors, checked by an exact predictor.
module vector3_normalizer_tb;
    import vn_pkg::*;

    typedef struct {
        logic signed [COORD_WIDTH-1:0] x, y, z;
        logic                          known;
        logic signed [OUT_W-1:0]       ux, uy, uz;
        logic                          zv;
    } t_row;

    typedef struct {
        logic signed [OUT_W-1:0] ux, uy, uz;
        logic                    zv;
    } t_unit;

    localparam int N_RANDOM = 700;
    localparam int LIMIT    = 400000;
    localparam logic signed [COORD_WIDTH-1:0] CMIN = -(2 ** (COORD_WIDTH - 1));
    localparam logic signed [COORD_WIDTH-1:0] CMAX = 2 ** (COORD_WIDTH - 1) - 1;
    localparam logic signed [OUT_W-1:0]       ONE  = 2 ** FRAC_BITS;

    logic                          i_clk = 0;
    logic                          i_rst_n = 0;
    logic                          i_valid = 0;
    logic                          o_stall;
    logic signed [COORD_WIDTH-1:0] i_comp_x = 0, i_comp_y = 0, i_comp_z = 0;
    logic                          o_valid;
    logic                          i_stall = 0;
    logic signed [OUT_W-1:0]       o_unit_x, o_unit_y, o_unit_z;
    logic                          o_zero_vector;

    t_unit  unit_queue[$];
    int     errors = 0;
    int     n_sent = 0;
    int     n_got = 0;
    int     n_zero = 0;
    int     cycles = 0;
    bit     hold_rx = 0;
    bit     quiet = 0;

    vector3_normalizer u_top (.*);

    always #2 i_clk = ~i_clk;

    // round(a * 2^F / sqrt(s)) by bitwise search on (2q-1)^2 * s <= a^2 * 2^(2F+2)
    function automatic logic [FRAC_BITS:0] unit_ratio(logic [63:0] a, logic [63:0] s);
        logic [FRAC_BITS:0] q;
        logic [FRAC_BITS:0] cand;
        logic [127:0]       rhs;
        logic [127:0]       lhs;
        logic [63:0]        odd;
        q = '0;
        rhs = (128'(a) * 128'(a)) << (2 * FRAC_BITS + 2);
        for (int b = FRAC_BITS; b >= 0; b--) begin
            cand = q | ((FRAC_BITS+1)'(1) << b);
            if (cand <= ONE) begin
                odd = 2 * 64'(cand) - 1;
                lhs = 128'(odd * odd) * 128'(s);
                if (lhs <= rhs) q = cand;
            end
        end
        return q;
    endfunction

    function automatic t_unit normalize(logic signed [COORD_WIDTH-1:0] x,
                                        logic signed [COORD_WIDTH-1:0] y,
                                        logic signed [COORD_WIDTH-1:0] z);
        t_unit       r;
        logic [63:0] m[3];
        logic [63:0] s;
        logic [FRAC_BITS:0] q;
        logic signed [COORD_WIDTH-1:0] c[3];
        c[0] = x; c[1] = y; c[2] = z;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            m[i] = c[i][COORD_WIDTH-1] ? 64'(-65'(c[i])) : 64'(c[i]);
            s += m[i] * m[i];
        end
        r.zv = (s == '0);
        r.ux = '0; r.uy = '0; r.uz = '0;
        if (s != '0) begin
            q = unit_ratio(m[0], s); r.ux = c[0][COORD_WIDTH-1] ? -OUT_W'(q) : OUT_W'(q);
            q = unit_ratio(m[1], s); r.uy = c[1][COORD_WIDTH-1] ? -OUT_W'(q) : OUT_W'(q);
            q = unit_ratio(m[2], s); r.uz = c[2][COORD_WIDTH-1] ? -OUT_W'(q) : OUT_W'(q);
        end
        return r;
    endfunction

    t_row dir_table[19] = '{
        '{0, 0, 0, 1, 0, 0, 0, 1},
        '{1, 0, 0, 1, ONE, 0, 0, 0},
        '{0, 1, 0, 1, 0, ONE, 0, 0},
        '{0, 0, -1, 1, 0, 0, -ONE, 0},
        '{CMAX, 0, 0, 1, ONE, 0, 0, 0},
        '{CMIN, 0, 0, 1, -ONE, 0, 0, 0},
        '{0, CMIN, 0, 1, 0, -ONE, 0, 0},
        '{0, 0, CMIN, 1, 0, 0, -ONE, 0},
        '{CMIN, CMIN, CMIN, 0, 0, 0, 0, 0},
        '{CMAX, CMAX, CMAX, 0, 0, 0, 0, 0},
        '{CMIN, CMAX, CMIN, 0, 0, 0, 0, 0},
        '{-1, -1, -1, 0, 0, 0, 0, 0},
        '{3, 4, 0, 0, 0, 0, 0, 0},
        '{1, 1, 0, 0, 0, 0, 0, 0},
        '{2, -2, 1, 0, 0, 0, 0, 0},
        '{16'h5555, 16'hAAAA, 16'h00FF, 0, 0, 0, 0, 0},
        '{16'hAAAA, 16'h5555, 16'hFF00, 0, 0, 0, 0, 0},
        '{1, CMAX, 0, 0, 0, 0, 0, 0},
        '{-1, 0, CMIN, 0, 0, 0, 0, 0}
    };

    task automatic send_vector(logic signed [COORD_WIDTH-1:0] x,
                               logic signed [COORD_WIDTH-1:0] y,
                               logic signed [COORD_WIDTH-1:0] z);
        while (!quiet && $urandom_range(99) < 14) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid  <= 1;
        i_comp_x <= x;
        i_comp_y <= y;
        i_comp_z <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_sent++;
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] rand_comp();
        case ($urandom_range(9))
            0:       return CMIN;
            1:       return CMAX;
            2:       return COORD_WIDTH'($urandom_range(8)) - COORD_WIDTH'(4);
            3:       return COORD_WIDTH'($urandom_range(255));
            default: return COORD_WIDTH'($urandom);
        endcase
    endfunction

    // expectation recorded at the accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            unit_queue.push_back(normalize(i_comp_x, i_comp_y, i_comp_z));
    end

    always @(posedge i_clk) begin
        t_unit e;
        cycles++;
        if (i_rst_n && o_valid && !i_stall) begin
            n_got++;
            if (unit_queue.size() == 0) begin
                $error("result with no transaction pending");
                errors++;
            end else begin
                e = unit_queue.pop_front();
                if (o_unit_x !== e.ux) begin
                    $error("unit_x exp %0d got %0d", e.ux, o_unit_x); errors++;
                end
                if (o_unit_y !== e.uy) begin
                    $error("unit_y exp %0d got %0d", e.uy, o_unit_y); errors++;
                end
                if (o_unit_z !== e.uz) begin
                    $error("unit_z exp %0d got %0d", e.uz, o_unit_z); errors++;
                end
                if (o_zero_vector !== e.zv) begin
                    $error("zero_vector exp %0b got %0b", e.zv, o_zero_vector); errors++;
                end
                if (e.zv) n_zero++;
            end
        end
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stall: random, long hold-off on request, quiet stretches
    always @(posedge i_clk) begin
        if (hold_rx) i_stall <= 1;
        else if (quiet) i_stall <= 0;
        else i_stall <= ($urandom_range(99) < 14);
    end

    initial begin
        t_unit e;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (dir_table[i]) begin
            if (dir_table[i].known) begin
                e = normalize(dir_table[i].x, dir_table[i].y, dir_table[i].z);
                if (e.ux !== dir_table[i].ux || e.uy !== dir_table[i].uy ||
                    e.uz !== dir_table[i].uz || e.zv !== dir_table[i].zv) begin
                    $error("table row %0d disagrees with predictor", i);
                    errors++;
                end
            end
            send_vector(dir_table[i].x, dir_table[i].y, dir_table[i].z);
        end

        // sender pause until drained
        i_valid <= 0;
        @(posedge i_clk);
        while (unit_queue.size() != 0) @(posedge i_clk);

        // receiver holds off while sender keeps offering
        hold_rx = 1;
        fork
            begin
                repeat (80) @(posedge i_clk);
                hold_rx = 0;
            end
            for (int i = 0; i < 60; i++) send_vector(rand_comp(), rand_comp(), rand_comp());
        join

        for (int i = 0; i < N_RANDOM - 60; i++) begin
            quiet = (i >= 200 && i < 300);
            send_vector(rand_comp(), rand_comp(), rand_comp());
        end
        quiet = 0;
        i_valid <= 0;
        @(posedge i_clk);

        while (unit_queue.size() != 0) @(posedge i_clk);
        repeat (3 * (FRAC_BITS + 6)) @(posedge i_clk);

        $display("covered %0d vectors (%0d zero), %0d results checked",
                 n_sent, n_zero, n_got);
        if (errors == 0 && unit_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

[files.f]
sv/vn_pkg.sv
sv/vector3_normalizer.sv
test/vector3_normalizer_tb.sv
